// File: sv/mlfd_pkg.sv
package mlfd_pkg;

  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned MAGIC_BYTES  = 4;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } item_t;

  localparam logic [2:0] STS_NONE      = 3'd0;
  localparam logic [2:0] STS_PAYLOAD   = 3'd1;
  localparam logic [2:0] STS_RESYNC    = 3'd2;
  localparam logic [2:0] STS_FLUSHED   = 3'd3;
  localparam logic [2:0] STS_PUSHED    = 3'd4;
  localparam logic [2:0] STS_PUSH_DROP = 3'd5;
  localparam logic [2:0] STS_EMPTY     = 3'd6;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic        last;
    logic [15:0] frame_length;
  } result_t;

  typedef struct packed {
    logic [15:0] max_frame_len;
    logic [3:0]  resync_limit;
    logic [31:0] magic_word;
  } cfg_t;

  localparam logic [1:0] CFG_MAX_FRAME_LEN = 2'd0;
  localparam logic [1:0] CFG_RESYNC_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_MAGIC_WORD    = 2'd2;

  localparam logic [15:0] MAX_FRAME_LEN_RST = 16'd1600;
  localparam logic [3:0]  RESYNC_LIMIT_RST  = 4'd3;
  localparam logic [31:0] MAGIC_WORD_RST    = 32'hAA55AA55;

endpackage

// File: sv/mlfd_ram.sv
module mlfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/mlfd_front.sv
module mlfd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  logic           action_i,
  input  logic [7:0]     data_i,
  output logic           item_valid_o,
  output mlfd_pkg::item_t item_o,
  input  logic           item_pop_i
);
  import mlfd_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  item_t      incoming;

  always_comb begin
    incoming.op   = action_i ? OP_PULL : OP_PUSH;
    incoming.data = data_i;
  end

  assign s_ready_o    = (count_q != 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];
  assign push         = s_valid_i && s_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= incoming;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: sv/mlfd_engine.sv
module mlfd_engine #(
  parameter int unsigned RING_DEPTH = 8192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mlfd_pkg::cfg_t    cfg_i,
  input  logic              item_valid_i,
  input  mlfd_pkg::item_t   item_i,
  output logic              item_pop_o,
  output logic              res_valid_o,
  output mlfd_pkg::result_t res_o,
  input  logic              res_ready_i
);
  import mlfd_pkg::*;

  localparam int unsigned AW  = $clog2(RING_DEPTH);
  localparam int unsigned FW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned HCW = $clog2(HEADER_BYTES + 1);
  localparam logic [FW:0]   DEPTH_S = (FW + 1)'(RING_DEPTH);
  localparam logic [FW-1:0] DEPTH_F = FW'(RING_DEPTH);
  localparam logic [FW-1:0] HDR_F   = FW'(HEADER_BYTES);
  localparam logic [FW-1:0] MAGIC_F = FW'(MAGIC_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_EVAL,
    S_ISSUE,
    S_DATA
  } state_e;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] p, logic [FW-1:0] n);
    logic [FW:0] s;
    s = (FW + 1)'(p) + (FW + 1)'(n);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  state_e           state_q, state_d;
  logic [AW-1:0]    rp_q, rp_d;
  logic [AW-1:0]    wp_q, wp_d;
  logic [FW-1:0]    fill_q, fill_d;
  logic [3:0]       tally_q, tally_d;
  logic             delivering_q, delivering_d;
  logic [15:0]      todel_q, todel_d;
  logic [FW-1:0]    skip_q, skip_d;
  logic [15:0]      hold_q, hold_d;
  logic [63:0]      hdr_q, hdr_d;
  logic [HCW-1:0]   cnt_q, cnt_d;
  logic             res_valid_q, res_valid_d;
  result_t          res_q, res_d;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;
  logic             out_free;
  logic [31:0]      magic, len;
  logic [15:0]      size;
  logic [FW-1:0]    drop_n, tail_n;

  mlfd_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (item_i.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !res_valid_q || res_ready_i;
  assign magic    = hdr_q[31:0];
  assign len      = hdr_q[63:32];
  assign size     = (len < {16'd0, cfg_i.max_frame_len}) ? len[15:0] : cfg_i.max_frame_len;
  assign tail_n   = (skip_q < fill_q - FW'(1)) ? skip_q : fill_q - FW'(1);

  always_comb begin
    state_d      = state_q;
    rp_d         = rp_q;
    wp_d         = wp_q;
    fill_d       = fill_q;
    tally_d      = tally_q;
    delivering_d = delivering_q;
    todel_d      = todel_q;
    skip_d       = skip_q;
    hold_d       = hold_q;
    hdr_d        = hdr_q;
    cnt_d        = cnt_q;
    res_valid_d  = res_valid_q && !res_ready_i;
    res_d        = res_q;
    item_pop_o   = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = rp_q;
    drop_n       = FW'(1);

    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          if (item_i.op == OP_PUSH) begin
            if (out_free) begin
              item_pop_o  = 1'b1;
              res_valid_d = 1'b1;
              res_d       = '0;
              if (fill_q == DEPTH_F) begin
                res_d.status = STS_PUSH_DROP;
              end else begin
                ram_we       = 1'b1;
                wp_d         = wrap_add(wp_q, FW'(1));
                fill_d       = fill_q + FW'(1);
                res_d.status = STS_PUSHED;
              end
            end
          end else if (delivering_q) begin
            item_pop_o = 1'b1;
            ram_re     = 1'b1;
            state_d    = S_DATA;
          end else if (fill_q < HDR_F) begin
            if (out_free) begin
              item_pop_o   = 1'b1;
              res_valid_d  = 1'b1;
              res_d        = '0;
              res_d.status = STS_NONE;
            end
          end else begin
            item_pop_o = 1'b1;
            ram_re     = 1'b1;
            cnt_d      = HCW'(1);
            state_d    = S_HDR;
          end
        end
      end

      S_HDR: begin
        hdr_d = {ram_rdata, hdr_q[63:8]};
        if (cnt_q == HCW'(HEADER_BYTES)) begin
          state_d = S_EVAL;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = wrap_add(rp_q, FW'(cnt_q));
          cnt_d     = cnt_q + HCW'(1);
        end
      end

      S_EVAL: begin
        if (magic != cfg_i.magic_word) begin
          if (out_free) begin
            res_valid_d = 1'b1;
            res_d       = '0;
            state_d     = S_IDLE;
            if (tally_q >= cfg_i.resync_limit) begin
              rp_d         = '0;
              wp_d         = '0;
              fill_d       = '0;
              tally_d      = '0;
              res_d.status = STS_FLUSHED;
            end else begin
              rp_d         = wrap_add(rp_q, MAGIC_F);
              fill_d       = fill_q - MAGIC_F;
              tally_d      = tally_q + 4'd1;
              res_d.status = STS_RESYNC;
            end
          end
        end else if (32'(fill_q - HDR_F) < len) begin
          if (out_free) begin
            tally_d      = '0;
            res_valid_d  = 1'b1;
            res_d        = '0;
            res_d.status = STS_NONE;
            state_d      = S_IDLE;
          end
        end else if (size == 16'd0) begin
          if (out_free) begin
            tally_d      = '0;
            rp_d         = wrap_add(rp_q, FW'(len) + HDR_F);
            fill_d       = fill_q - FW'(len) - HDR_F;
            res_valid_d  = 1'b1;
            res_d        = '0;
            res_d.status = STS_EMPTY;
            state_d      = S_IDLE;
          end
        end else begin
          tally_d      = '0;
          rp_d         = wrap_add(rp_q, HDR_F);
          fill_d       = fill_q - HDR_F;
          skip_d       = FW'(len - 32'(size));
          hold_d       = size;
          todel_d      = size;
          delivering_d = 1'b1;
          state_d      = S_ISSUE;
        end
      end

      S_ISSUE: begin
        ram_re  = 1'b1;
        state_d = S_DATA;
      end

      S_DATA: begin
        if (out_free) begin
          res_valid_d        = 1'b1;
          res_d.status       = STS_PAYLOAD;
          res_d.payload_byte = ram_rdata;
          res_d.frame_length = hold_q;
          res_d.last         = 1'b0;
          if (todel_q <= 16'd1) begin
            res_d.last   = 1'b1;
            delivering_d = 1'b0;
            todel_d      = '0;
            skip_d       = '0;
            drop_n       = FW'(1) + tail_n;
          end else begin
            todel_d = todel_q - 16'd1;
          end
          rp_d    = wrap_add(rp_q, drop_n);
          fill_d  = fill_q - drop_n;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rp_q         <= '0;
      wp_q         <= '0;
      fill_q       <= '0;
      tally_q      <= '0;
      delivering_q <= 1'b0;
      todel_q      <= '0;
      skip_q       <= '0;
      hold_q       <= '0;
      hdr_q        <= '0;
      cnt_q        <= '0;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      rp_q         <= rp_d;
      wp_q         <= wp_d;
      fill_q       <= fill_d;
      tally_q      <= tally_d;
      delivering_q <= delivering_d;
      todel_q      <= todel_d;
      skip_q       <= skip_d;
      hold_q       <= hold_d;
      hdr_q        <= hdr_d;
      cnt_q        <= cnt_d;
      res_valid_q  <= res_valid_d;
      res_q        <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: sv/magic_length_frame_deframer.sv
// Channel   Direction  Beat contents
// s_axis    in         tdata: data_byte; tuser: action (0 push, 1 pull)
// m_axis    out        tdata: payload_byte, frame_length; tuser: status; tlast: last
// cfg       in         write enable, register index, write data
//
// A push is handled in the back end's idle state, and a payload pull reads the ring, then
// gives the result. A pull that examines a header reads one header byte at a time from the
// ring's single read port (a start state, the header states, then an evaluate state), then
// does a ring read and gives the result when the first payload byte follows.
// A two-entry queue keeps accepting beats while the back end works, and the result
// register holds a beat through output stalls. Reset needs no clearing pass over the ring.
module magic_length_frame_deframer #(
  parameter int unsigned RING_DEPTH = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic [0:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // payload_byte, frame_length
  output logic [2:0]  m_axis_tuser,  // status
  output logic        m_axis_tlast
);
  import mlfd_pkg::*;

  cfg_t    cfg_q;
  item_t   item;
  logic    item_valid, item_pop;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_frame_len <= MAX_FRAME_LEN_RST;
      cfg_q.resync_limit  <= RESYNC_LIMIT_RST;
      cfg_q.magic_word    <= MAGIC_WORD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_FRAME_LEN: cfg_q.max_frame_len <= cfg_wdata_i[15:0];
        CFG_RESYNC_LIMIT:  cfg_q.resync_limit  <= cfg_wdata_i[3:0];
        CFG_MAGIC_WORD:    cfg_q.magic_word    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  mlfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .action_i     (s_axis_tuser[0]),
    .data_i       (s_axis_tdata),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  mlfd_engine #(
    .RING_DEPTH (RING_DEPTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_o        (res),
    .res_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {res.frame_length, res.payload_byte};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

endmodule
